FILE: rtl/core/ccds_pkg.sv
// ---------------------------------------------------------------------------
// Clearance cost direction select: shared package
// Widths, constants, register indexes and types used across the block.
// ---------------------------------------------------------------------------
package ccds_pkg;

   // Scan geometry
   localparam int CANDIDATES = 19;
   localparam int SPAN       = CANDIDATES - 1;
   localparam int CENTRE     = CANDIDATES / 2;
   localparam int CNT_W      = $clog2(CANDIDATES);

   // Field widths
   localparam int CLEAR_W    = 15;
   localparam int HEAD_W     = 16;
   localparam int WGT_W      = 12;
   localparam int IDX_W      = 5;
   localparam int FRAC_W     = 10;
   localparam int COST_W     = 18;
   localparam int PROD_W     = WGT_W + CLEAR_W;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_USER_HEADING     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DISTANCE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_DISTANCE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKED_COST     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE_WEIGHT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVIATION_WEIGHT = 3'd5;

   // Register reset values
   localparam logic signed [HEAD_W-1:0] RST_USER_HEADING = '0;
   localparam logic [CLEAR_W-1:0] RST_STOP_DISTANCE    = 15'd614;
   localparam logic [CLEAR_W-1:0] RST_SLOW_DISTANCE    = 15'd1126;
   localparam logic [CLEAR_W-1:0] RST_BLOCKED_COST     = 15'd10240;
   localparam logic [WGT_W-1:0]   RST_OBSTACLE_WEIGHT  = 12'd1024;
   localparam logic [WGT_W-1:0]   RST_DEVIATION_WEIGHT = 12'd358;

   // Heading limit: 45 degrees in Q3.13 radians
   localparam int DEV_MAX_Q13 = 6434;
   localparam logic signed [HEAD_W-1:0] HEAD_MAX = HEAD_W'(DEV_MAX_Q13);
   localparam logic signed [HEAD_W-1:0] HEAD_MIN = -HEAD_W'(DEV_MAX_Q13);

   localparam logic [CLEAR_W-1:0] FREE_CLEAR = '1;
   localparam logic [COST_W-1:0]  COST_INF   = '1;

   // Deviation arithmetic: signed difference and its normalising divisor
   localparam int DEV_DIV     = DEV_MAX_Q13 * SPAN;
   localparam int DEV_ABS_MAX = 2 * DEV_DIV;
   localparam int DEV_W       = $clog2(DEV_ABS_MAX + 1) + 1;

   // The constant division is a multiply by the rounded-up reciprocal. The
   // shift is wide enough that the floor stays exact over the whole range.
   localparam int     DEV_RECIP_SH  = 34;
   localparam longint DEV_RECIP_VAL =
      ((longint'(1) << (DEV_RECIP_SH + FRAC_W)) + longint'(DEV_DIV) - 1)
      / longint'(DEV_DIV);
   localparam int     RECIP_W       = $clog2(DEV_RECIP_VAL + 1);
   localparam logic [RECIP_W-1:0] DEV_RECIP = RECIP_W'(DEV_RECIP_VAL);
   localparam int     DEV_PROD_W    = (DEV_W - 1) + RECIP_W;

   // Shared divider: quotient bits, divisor and dividend widths
   localparam int QUO_W   = 12;
   localparam int DIV_W   = CLEAR_W;
   localparam int NUM_W   = DIV_W + QUO_W;
   localparam int STEP_W  = $clog2(QUO_W);
   localparam logic [QUO_W-1:0] DEV_LIMIT = QUO_W'(2 ** (FRAC_W + 1));

   // Configuration as seen by the datapath, heading already clamped
   typedef struct packed {
      logic signed [HEAD_W-1:0] heading;
      logic [CLEAR_W-1:0]       stop_dist;
      logic [CLEAR_W-1:0]       slow_dist;
      logic [CLEAR_W-1:0]       block_pen;
      logic [WGT_W-1:0]         obs_weight;
      logic [WGT_W-1:0]         dev_weight;
   } cfg_type;

   // Divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEV_SCALE,
      ST_OBS_DIV,
      ST_MUL_DEV,
      ST_MUL_OBS,
      ST_UPDATE
   } state_type;

endpackage

FILE: rtl/core/ccds_req_if.sv
// ---------------------------------------------------------------------------
// Clearance cost direction select: request channel
// Valid/ready channel carrying one candidate clearance per request.
// ---------------------------------------------------------------------------
interface ccds_req_if import ccds_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [CLEAR_W-1:0] clearance;

   modport source (output valid, output clearance, input ready);
   modport sink   (input valid, input clearance, output ready);

endinterface

FILE: rtl/core/ccds_rsp_if.sv
// ---------------------------------------------------------------------------
// Clearance cost direction select: result channel
// Valid/ready channel carrying the chosen direction of one scan.
// ---------------------------------------------------------------------------
interface ccds_rsp_if import ccds_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [IDX_W-1:0]   best_index;
   logic               no_path;
   logic [CLEAR_W-1:0] front_clearance;

   modport source (output valid, output best_index, output no_path,
                   output front_clearance, input ready);
   modport sink   (input valid, input best_index, input no_path,
                   input front_clearance, output ready);

endinterface

FILE: rtl/core/clearance_cost_direction_select.sv
// ---------------------------------------------------------------------------
// Clearance cost direction select: top level
// Costs each steering candidate of a scan and picks the cheapest direction.
// ---------------------------------------------------------------------------
// Usage:
//  req_ch carries one candidate clearance per request, in scan order from
//  the -45 degree candidate to the +45 degree one; 19 requests form a scan.
//  After the last request of a scan one result appears on rsp_ch: the best
//  candidate index, the all-blocked flag and the centre clearance.
//  csr_we/csr_index/csr_wdata write the six configuration registers; write
//  them only while no request is being worked on.
//  A request passes through the acceptance step, the deviation scaling, the
//  two multiply steps and the compare; a clearance on the slow-down ramp
//  also waits in the shared divider for the ramp fraction between the
//  scaling and the multiplies. A new request is accepted only once the
//  previous one has left the compare.
//  The result sits in an output register, so the next scan is accepted while
//  it waits. Only if a further scan completes before the receiver takes the
//  earlier result does the block hold in its last step until rsp_ch.ready.
//  Synchronous reset restores the register defaults and starts a new scan;
//  no result is pending after reset.
// ---------------------------------------------------------------------------
module clearance_cost_direction_select import ccds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ccds_req_if.sink              req_ch,
   ccds_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [CNT_W-1:0] LAST_CNT   = CNT_W'(CANDIDATES - 1);
   localparam logic [CNT_W-1:0] CENTRE_CNT = CNT_W'(CENTRE);

   cfg_type            cfg;
   div_stat_type       div_stat;
   logic [QUO_W-1:0]   div_quo;
   logic               div_start;
   logic [NUM_W-1:0]   div_numer;
   logic [DIV_W-1:0]   div_divisor;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COST_W-1:0]  min_cost_ff, min_cost_in;
   logic [CNT_W-1:0]   best_idx_ff, best_idx_in;
   logic               passable_ff, passable_in;
   logic [CLEAR_W-1:0] front_ff, front_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [CLEAR_W-1:0] clear_ff, clear_in;
   logic [DEV_W-2:0]   dev_abs_ff, dev_abs_in;
   logic [QUO_W-1:0]   dev_ff, dev_in;
   logic [CLEAR_W-1:0] obs_ff, obs_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [COST_W-1:0]  cost_ff, cost_in;
   logic [IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic               rsp_blk_ff, rsp_blk_in;
   logic [CLEAR_W-1:0] rsp_front_ff, rsp_front_in;

   logic signed [DEV_W-1:0] pos_term, hdg_term, dev_diff, dev_mag;
   logic [DEV_W-2:0]        dev_abs;
   logic [DEV_PROD_W-1:0]   dev_prod;
   logic [CLEAR_W-1:0]      ramp_diff;
   logic [WGT_W-1:0]        mul_a;
   logic [CLEAR_W-1:0]      mul_b;
   logic [COST_W-1:0]       cost_sum;
   logic                    better;
   logic                    is_last;
   logic                    rsp_stall;
   logic                    passable_new;
   logic [CNT_W-1:0]        best_idx_new;
   logic [CLEAR_W-1:0]      front_new;

   ccds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ccds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // Signed angle offset of the current candidate from the heading, scaled so
   // that 45 degrees maps to the deviation divisor.
   always_comb begin
      pos_term  = (DEV_W'({cnt_ff, 1'b0}) - DEV_W'(SPAN)) * DEV_W'(DEV_MAX_Q13);
      hdg_term  = DEV_W'(cfg.heading) * DEV_W'(SPAN);
      dev_diff  = pos_term - hdg_term;
      dev_mag   = dev_diff[DEV_W-1] ? -dev_diff : dev_diff;
      dev_abs   = dev_mag[DEV_W-2:0];
      ramp_diff = cfg.slow_dist - clear_ff;
   end

   // Normalised deviation of the registered offset by reciprocal multiply.
   always_comb begin
      dev_prod = DEV_PROD_W'(dev_abs_ff) * DEV_PROD_W'(DEV_RECIP);
   end

   // Shared multiplier operands follow the step.
   always_comb begin
      mul_a = cfg.obs_weight;
      mul_b = obs_ff;
      if (state_ff == ST_MUL_DEV) begin
         mul_a = cfg.dev_weight;
         mul_b = CLEAR_W'(dev_ff);
      end
   end

   // Running argmin and scan bookkeeping for the current candidate.
   always_comb begin
      cost_sum     = cost_ff + COST_W'(prod_ff >> FRAC_W);
      better       = cost_sum < min_cost_ff;
      is_last      = cnt_ff == LAST_CNT;
      rsp_stall    = rsp_valid_ff && !rsp_ch.ready;
      passable_new = passable_ff || (obs_ff < cfg.block_pen);
      best_idx_new = better ? cnt_ff : best_idx_ff;
      front_new    = (cnt_ff == CENTRE_CNT) ? clear_ff : front_ff;
   end

   // Sequencer: next state, datapath loads and divider requests.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      min_cost_in  = min_cost_ff;
      best_idx_in  = best_idx_ff;
      passable_in  = passable_ff;
      front_in     = front_ff;
      rsp_valid_in = rsp_stall;
      clear_in     = clear_ff;
      dev_abs_in   = dev_abs_ff;
      dev_in       = dev_ff;
      obs_in       = obs_ff;
      prod_in      = prod_ff;
      cost_in      = cost_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_blk_in   = rsp_blk_ff;
      rsp_front_in = rsp_front_ff;
      div_start    = 1'b0;
      div_numer    = NUM_W'({ramp_diff, {FRAC_W{1'b0}}});
      div_divisor  = DIV_W'(cfg.slow_dist - cfg.stop_dist);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               clear_in   = req_ch.clearance;
               dev_abs_in = dev_abs;
               state_in   = ST_DEV_SCALE;
            end
         end
         ST_DEV_SCALE: begin
            dev_in = dev_prod[DEV_RECIP_SH +: QUO_W];
            priority if (clear_ff == FREE_CLEAR || clear_ff >= cfg.slow_dist) begin
               obs_in   = '0;
               state_in = ST_MUL_DEV;
            end else if (clear_ff <= cfg.stop_dist) begin
               obs_in   = cfg.block_pen;
               state_in = ST_MUL_DEV;
            end else begin
               div_start = 1'b1;
               state_in  = ST_OBS_DIV;
            end
         end
         ST_OBS_DIV: begin
            if (div_stat.done) begin
               obs_in   = CLEAR_W'(div_quo);
               state_in = ST_MUL_DEV;
            end
         end
         ST_MUL_DEV: begin
            prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
            state_in = ST_MUL_OBS;
         end
         ST_MUL_OBS: begin
            cost_in  = COST_W'(prod_ff >> FRAC_W);
            prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!(is_last && rsp_stall)) begin
               front_in = front_new;
               state_in = ST_IDLE;
               if (is_last) begin
                  rsp_idx_in   = IDX_W'(best_idx_new);
                  rsp_blk_in   = !passable_new;
                  rsp_front_in = front_new;
                  rsp_valid_in = 1'b1;
                  cnt_in       = '0;
                  min_cost_in  = COST_INF;
                  best_idx_in  = CENTRE_CNT;
                  passable_in  = 1'b0;
               end else begin
                  cnt_in      = cnt_ff + 1'b1;
                  passable_in = passable_new;
                  best_idx_in = best_idx_new;
                  if (better) begin
                     min_cost_in = cost_sum;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         min_cost_ff  <= COST_INF;
         best_idx_ff  <= CENTRE_CNT;
         passable_ff  <= 1'b0;
         front_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         min_cost_ff  <= min_cost_in;
         best_idx_ff  <= best_idx_in;
         passable_ff  <= passable_in;
         front_ff     <= front_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and result payload.
   always_ff @(posedge clock) begin
      clear_ff     <= clear_in;
      dev_abs_ff   <= dev_abs_in;
      dev_ff       <= dev_in;
      obs_ff       <= obs_in;
      prod_ff      <= prod_in;
      cost_ff      <= cost_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_blk_ff   <= rsp_blk_in;
      rsp_front_ff <= rsp_front_in;
   end

   assign req_ch.ready           = state_ff == ST_IDLE;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.best_index      = rsp_idx_ff;
   assign rsp_ch.no_path         = rsp_blk_ff;
   assign rsp_ch.front_clearance = rsp_front_ff;

   // The divider is only asked for work when it is free.
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // The normalised deviation never exceeds two in Q.10.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEV_SCALE) |-> (dev_in <= DEV_LIMIT))
      else $error("deviation out of range");

   // The multiply steps are only reached from a finished obstacle decision.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_DEV) |-> ($past(state_ff) == ST_DEV_SCALE || $past(div_stat.done)))
      else $error("multiply step entered without an obstacle term");

   // Issuing a result restarts the scan state.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && is_last && !rsp_stall)
         |=> (cnt_ff == '0 && min_cost_ff == COST_INF && rsp_ch.valid))
      else $error("scan state not restarted after a result");

endmodule

FILE: rtl/core/ccds_csr.sv
// ---------------------------------------------------------------------------
// Clearance cost direction select: configuration registers
// Write-only register file; presents the heading clamped to +-45 degrees.
// ---------------------------------------------------------------------------
module ccds_csr import ccds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic signed [HEAD_W-1:0] heading_ff, heading_in;
   logic [CLEAR_W-1:0]       stop_ff, stop_in;
   logic [CLEAR_W-1:0]       slow_ff, slow_in;
   logic [CLEAR_W-1:0]       blocked_ff, blocked_in;
   logic [WGT_W-1:0]         obs_wgt_ff, obs_wgt_in;
   logic [WGT_W-1:0]         dev_wgt_ff, dev_wgt_in;

   // Decode a write; each register keeps only its own width.
   always_comb begin
      heading_in = heading_ff;
      stop_in    = stop_ff;
      slow_in    = slow_ff;
      blocked_in = blocked_ff;
      obs_wgt_in = obs_wgt_ff;
      dev_wgt_in = dev_wgt_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_USER_HEADING:     heading_in = signed'(csr_wdata[HEAD_W-1:0]);
            CSR_STOP_DISTANCE:    stop_in    = csr_wdata[CLEAR_W-1:0];
            CSR_SLOW_DISTANCE:    slow_in    = csr_wdata[CLEAR_W-1:0];
            CSR_BLOCKED_COST:     blocked_in = csr_wdata[CLEAR_W-1:0];
            CSR_OBSTACLE_WEIGHT:  obs_wgt_in = csr_wdata[WGT_W-1:0];
            CSR_DEVIATION_WEIGHT: dev_wgt_in = csr_wdata[WGT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= RST_USER_HEADING;
         stop_ff    <= RST_STOP_DISTANCE;
         slow_ff    <= RST_SLOW_DISTANCE;
         blocked_ff <= RST_BLOCKED_COST;
         obs_wgt_ff <= RST_OBSTACLE_WEIGHT;
         dev_wgt_ff <= RST_DEVIATION_WEIGHT;
      end else begin
         heading_ff <= heading_in;
         stop_ff    <= stop_in;
         slow_ff    <= slow_in;
         blocked_ff <= blocked_in;
         obs_wgt_ff <= obs_wgt_in;
         dev_wgt_ff <= dev_wgt_in;
      end
   end

   // Clamp the heading to the candidate fan.
   always_comb begin
      cfg.heading      = heading_ff;
      if (heading_ff > HEAD_MAX) begin
         cfg.heading = HEAD_MAX;
      end else if (heading_ff < HEAD_MIN) begin
         cfg.heading = HEAD_MIN;
      end
      cfg.stop_dist    = stop_ff;
      cfg.slow_dist    = slow_ff;
      cfg.block_pen    = blocked_ff;
      cfg.obs_weight   = obs_wgt_ff;
      cfg.dev_weight   = dev_wgt_ff;
   end

endmodule

FILE: rtl/core/ccds_div.sv
// ---------------------------------------------------------------------------
// Clearance cost direction select: shared divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ccds_div import ccds_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   numer,
   input  logic [DIV_W-1:0]   divisor,
   output div_stat_type       stat,
   output logic [QUO_W-1:0]   quotient
);

   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  dsh_ff, dsh_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              fits;

   // The dividend is known to be below divisor * 2^QUO_W, so the divisor is
   // aligned to the top quotient bit and walked down one place per cycle.
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      fits    = rem_ff >= dsh_ff;
      if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[QUO_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end else if (start) begin
         rem_in  = numer;
         dsh_in  = NUM_W'(divisor) << (QUO_W - 1);
         quo_in  = '0;
         step_in = STEP_W'(QUO_W - 1);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
